// ----- sv/nfsp_pkg.sv -----
// Shared types and constants of the next-fit slot pool.
package nfsp_pkg;

	localparam int OP_BITS   = 2;
	localparam int SLOT_IN_BITS = 7;
	localparam int SLOT_BITS = 6;
	localparam int DATA_BITS = 64;

	typedef enum logic [OP_BITS-1:0] {
		OP_ALLOC = 2'd0,
		OP_FREE  = 2'd1,
		OP_READ  = 2'd2,
		OP_WRITE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	typedef struct packed {
		op_t                     operation;
		logic [SLOT_IN_BITS-1:0] slot;
		logic [DATA_BITS-1:0]    write_data;
	} req_t;

	typedef struct packed {
		status_t              status;
		logic [SLOT_BITS-1:0] granted_slot;
		logic [DATA_BITS-1:0] read_data;
	} rsp_t;

	typedef struct packed {
		logic                 found;
		logic [SLOT_BITS-1:0] idx;
	} srch_res_t;

endpackage

// ----- sv/nfsp_store.sv -----
// Slot data memory: one port, registered read data.
module nfsp_store #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 64
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

// ----- sv/nfsp_search.sv -----
// Rotated first-free search over the used flags, two levels with a register between.
module nfsp_search #(
	parameter int POOL_SLOTS = 64
) (
	input  logic                          clk,
	input  logic                          load,
	input  logic [POOL_SLOTS-1:0]         used,
	input  logic [nfsp_pkg::SLOT_BITS-1:0] ptr,
	output nfsp_pkg::srch_res_t           res
);

	localparam int SB   = nfsp_pkg::SLOT_BITS;
	localparam int NGRP = (POOL_SLOTS + 7) / 8;
	localparam int GW   = (NGRP > 1) ? $clog2(NGRP) : 1;
	localparam int NPAD = NGRP * 8;

	logic [NPAD-1:0] free_pad;
	logic [NPAD-1:0] hi_pad;
	logic [NGRP-1:0] any_hi_d, any_hi_q;
	logic [NGRP-1:0] any_fr_d, any_fr_q;
	logic [2:0]      sub_hi_d [NGRP];
	logic [2:0]      sub_hi_q [NGRP];
	logic [2:0]      sub_fr_d [NGRP];
	logic [2:0]      sub_fr_q [NGRP];
	logic            use_hi;
	logic [GW-1:0]   gsel;
	logic [2:0]      sub;

	always_comb begin
		free_pad = '0;
		free_pad[POOL_SLOTS-1:0] = ~used;
		for (int i = 0; i < NPAD; i++) begin
			hi_pad[i] = free_pad[i] && (SB'(i) >= ptr);
		end
		for (int g = 0; g < NGRP; g++) begin
			any_hi_d[g] = |hi_pad[g*8 +: 8];
			any_fr_d[g] = |free_pad[g*8 +: 8];
			sub_hi_d[g] = '0;
			sub_fr_d[g] = '0;
			for (int b = 7; b >= 0; b--) begin
				if (hi_pad[g*8 + b]) begin
					sub_hi_d[g] = 3'(b);
				end
				if (free_pad[g*8 + b]) begin
					sub_fr_d[g] = 3'(b);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			any_hi_q <= any_hi_d;
			any_fr_q <= any_fr_d;
			sub_hi_q <= sub_hi_d;
			sub_fr_q <= sub_fr_d;
		end
	end

	always_comb begin
		use_hi = |any_hi_q;
		gsel   = '0;
		for (int g = NGRP - 1; g >= 0; g--) begin
			if (use_hi ? any_hi_q[g] : any_fr_q[g]) begin
				gsel = GW'(g);
			end
		end
		sub       = use_hi ? sub_hi_q[gsel] : sub_fr_q[gsel];
		res.found = |any_fr_q;
		res.idx   = SB'({gsel, sub});
	end

endmodule

// ----- sv/next_fit_slot_pool.sv -----
// Top level of the next-fit slot pool: request control, used flags, pointer, response register.
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+----------------------
//  request | req_valid | req_stall | req (nfsp_pkg::req_t)
//  result  | rsp_valid | rsp_stall | rsp (nfsp_pkg::rsp_t)
//
// For each request, the transfer edge issues the memory access and registers the
// first search level; the edge on which the second stage fires resolves the search,
// updates flags and pointer, and loads the result register.
// A new request is taken only once the previous one has left the second stage.
// Reset clears used flags, pointer and valids at once; the data memory is not cleared.
// A stalled result holds the second stage and with it the request side.
module next_fit_slot_pool #(
	parameter int POOL_SLOTS = 64,
	parameter int WORD_BITS  = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  nfsp_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output nfsp_pkg::rsp_t rsp
);

	localparam int AW = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
	localparam int SB = nfsp_pkg::SLOT_BITS;
	localparam int DB = nfsp_pkg::DATA_BITS;
	localparam int SI = nfsp_pkg::SLOT_IN_BITS;

	logic                  accept;
	logic                  fire;
	logic                  in_range;
	logic                  mem_en;
	logic [WORD_BITS-1:0]  rdata;
	nfsp_pkg::srch_res_t   res;

	logic                  s1_valid_q;
	nfsp_pkg::op_t         op_s1;
	logic [AW-1:0]         slot_s1;
	logic                  range_s1;

	logic [POOL_SLOTS-1:0] used_q;
	logic [SB-1:0]         ptr_q;
	logic                  rsp_valid_q;
	nfsp_pkg::rsp_t        rsp_q;

	assign req_stall = s1_valid_q;
	assign accept    = req_valid && !req_stall;
	assign fire      = s1_valid_q && (!rsp_valid_q || !rsp_stall);
	assign in_range  = req.slot < SI'(POOL_SLOTS);
	assign mem_en    = accept && in_range &&
		(req.operation == nfsp_pkg::OP_READ || req.operation == nfsp_pkg::OP_WRITE);

	nfsp_store #(
		.DEPTH(POOL_SLOTS),
		.WIDTH(WORD_BITS)
	) u_store (
		.clk  (clk),
		.en   (mem_en),
		.we   (req.operation == nfsp_pkg::OP_WRITE),
		.addr (req.slot[AW-1:0]),
		.wdata(req.write_data[WORD_BITS-1:0]),
		.rdata(rdata)
	);

	nfsp_search #(
		.POOL_SLOTS(POOL_SLOTS)
	) u_search (
		.clk (clk),
		.load(accept),
		.used(used_q),
		.ptr (ptr_q),
		.res (res)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1    <= req.operation;
			slot_s1  <= req.slot[AW-1:0];
			range_s1 <= in_range;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			rsp_valid_q <= 1'b0;
			used_q      <= '0;
			ptr_q       <= '0;
		end else begin
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (fire) begin
				s1_valid_q <= 1'b0;
			end
			if (fire) begin
				rsp_valid_q <= 1'b1;
				unique case (op_s1)
					nfsp_pkg::OP_ALLOC: begin
						if (res.found) begin
							used_q[res.idx[AW-1:0]] <= 1'b1;
							ptr_q                   <= res.idx;
						end
					end
					nfsp_pkg::OP_FREE: begin
						if (range_s1) begin
							used_q[slot_s1] <= 1'b0;
						end
					end
					nfsp_pkg::OP_READ, nfsp_pkg::OP_WRITE: begin
					end
				endcase
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			if (op_s1 == nfsp_pkg::OP_ALLOC) begin
				rsp_q.read_data <= '0;
				if (res.found) begin
					rsp_q.status       <= nfsp_pkg::ST_OK;
					rsp_q.granted_slot <= res.idx;
				end else begin
					rsp_q.status       <= nfsp_pkg::ST_FULL;
					rsp_q.granted_slot <= '0;
				end
			end else if (!range_s1) begin
				rsp_q.status       <= nfsp_pkg::ST_RANGE;
				rsp_q.granted_slot <= '0;
				rsp_q.read_data    <= '0;
			end else begin
				rsp_q.status       <= nfsp_pkg::ST_OK;
				rsp_q.granted_slot <= '0;
				rsp_q.read_data    <= (op_s1 == nfsp_pkg::OP_READ) ? DB'(rdata) : '0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_grant_was_free: assert property (@(posedge clk) disable iff (!arst_n)
		fire && op_s1 == nfsp_pkg::OP_ALLOC && res.found |-> !used_q[res.idx[AW-1:0]])
		else $error("allocate granted a slot already in use");

	a_full_means_all_used: assert property (@(posedge clk) disable iff (!arst_n)
		fire && op_s1 == nfsp_pkg::OP_ALLOC && !res.found |-> &used_q)
		else $error("allocate reported full with a free slot");

	a_grant_in_pool: assert property (@(posedge clk) disable iff (!arst_n)
		fire && op_s1 == nfsp_pkg::OP_ALLOC && res.found |-> res.idx < SB'(POOL_SLOTS - 1) ||
		res.idx == SB'(POOL_SLOTS - 1))
		else $error("granted slot beyond pool size");

	a_ptr_follows_grant: assert property (@(posedge clk) disable iff (!arst_n)
		fire && op_s1 == nfsp_pkg::OP_ALLOC && res.found |=> ptr_q == $past(res.idx))
		else $error("pointer not left on granted slot");

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench of the next-fit slot pool: directed and random requests, scoreboard.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int POOL       = 64;
	localparam int WBITS      = 64;
	localparam int HOLD_LEN   = 80;
	localparam int IDLE_LIMIT = 3000;
	localparam logic [nfsp_pkg::DATA_BITS-1:0] WORD_MASK =
		{nfsp_pkg::DATA_BITS{1'b1}} >> (nfsp_pkg::DATA_BITS - WBITS);

	logic           clk       = 1'b0;
	logic           arst_n    = 1'b0;
	logic           req_valid = 1'b0;
	logic           req_stall;
	nfsp_pkg::req_t req       = '0;
	logic           rsp_valid;
	logic           rsp_stall = 1'b0;
	nfsp_pkg::rsp_t rsp;

	next_fit_slot_pool #(
		.POOL_SLOTS(POOL),
		.WORD_BITS (WBITS)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	always #2 clk = ~clk;

	// pool image kept alongside the block
	bit                             used_flag [POOL];
	bit                             slot_written [POOL];
	logic [nfsp_pkg::DATA_BITS-1:0] slot_word [POOL];
	int unsigned                    search_ptr;
	nfsp_pkg::status_t              last_status;
	logic [nfsp_pkg::SLOT_BITS-1:0] last_grant;

	nfsp_pkg::rsp_t expected_rsp[$];

	int send_idle = 0;
	int rcv_idle  = 0;
	logic hold_req = 1'b0;
	int n_req, n_full, n_range, n_checked, n_errors;
	int n_op [4];

	function automatic nfsp_pkg::rsp_t pool_response(input nfsp_pkg::req_t item);
		nfsp_pkg::rsp_t o;
		int c;
		o.status       = nfsp_pkg::ST_OK;
		o.granted_slot = '0;
		o.read_data    = '0;
		n_req++;
		n_op[item.operation]++;
		if (item.operation == nfsp_pkg::OP_ALLOC) begin
			o.status = nfsp_pkg::ST_FULL;
			for (int k = 0; k < POOL; k++) begin
				c = (search_ptr + k) % POOL;
				if (!used_flag[c]) begin
					used_flag[c]   = 1'b1;
					search_ptr     = c;
					o.status       = nfsp_pkg::ST_OK;
					o.granted_slot = c[nfsp_pkg::SLOT_BITS-1:0];
					break;
				end
			end
			if (o.status == nfsp_pkg::ST_FULL)
				n_full++;
		end else if (item.slot >= POOL) begin
			o.status = nfsp_pkg::ST_RANGE;
			n_range++;
		end else begin
			case (item.operation)
				nfsp_pkg::OP_FREE: used_flag[item.slot] = 1'b0;
				nfsp_pkg::OP_READ: o.read_data = slot_word[item.slot] & WORD_MASK;
				nfsp_pkg::OP_WRITE: begin
					slot_word[item.slot]    = item.write_data & WORD_MASK;
					slot_written[item.slot] = 1'b1;
				end
				default: ;
			endcase
		end
		last_status = o.status;
		last_grant  = o.granted_slot;
		return o;
	endfunction

	function automatic nfsp_pkg::req_t mk_req(input nfsp_pkg::op_t op, input int s,
			input logic [nfsp_pkg::DATA_BITS-1:0] d);
		nfsp_pkg::req_t r;
		r.operation  = op;
		r.slot       = s[nfsp_pkg::SLOT_IN_BITS-1:0];
		r.write_data = d;
		return r;
	endfunction

	function automatic int find_set(input bit marks [POOL], input int start);
		int c;
		for (int k = 0; k < POOL; k++) begin
			c = (start + k) % POOL;
			if (marks[c])
				return c;
		end
		return -1;
	endfunction

	function automatic nfsp_pkg::req_t random_req();
		int pick, s, hit;
		nfsp_pkg::op_t op;
		pick = $urandom_range(0, 99);
		if (pick < 10)
			op = nfsp_pkg::OP_ALLOC;
		else if (pick < 50)
			op = nfsp_pkg::OP_FREE;
		else if (pick < 75)
			op = nfsp_pkg::OP_READ;
		else
			op = nfsp_pkg::OP_WRITE;
		if ($urandom_range(0, 99) < 12)
			s = $urandom_range(POOL, 127);
		else
			s = $urandom_range(0, POOL - 1);
		if (op == nfsp_pkg::OP_FREE && s < POOL && $urandom_range(0, 99) < 85) begin
			hit = find_set(used_flag, s);
			if (hit >= 0)
				s = hit;
		end
		if (op == nfsp_pkg::OP_READ && s < POOL && !slot_written[s])
			s = find_set(slot_written, s);
		return mk_req(op, s, {$urandom, $urandom});
	endfunction

	task automatic send_req(input nfsp_pkg::req_t item);
		while ($urandom_range(0, 99) < send_idle) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= item;
		do
			@(posedge clk);
		while (req_stall);
		expected_rsp.push_back(pool_response(item));
	endtask

	task automatic check_rsp(input nfsp_pkg::rsp_t got);
		nfsp_pkg::rsp_t want;
		if (expected_rsp.size() == 0) begin
			$display("%0t: result with none expected: status %0d slot %0d data %h",
				$time, got.status, got.granted_slot, got.read_data);
			n_errors++;
		end else begin
			want = expected_rsp.pop_front();
			n_checked++;
			if (got.status !== want.status) begin
				$display("%0t: status mismatch: expected %0d, actual %0d",
					$time, want.status, got.status);
				n_errors++;
			end
			if (got.granted_slot !== want.granted_slot) begin
				$display("%0t: granted_slot mismatch: expected %0d, actual %0d",
					$time, want.granted_slot, got.granted_slot);
				n_errors++;
			end
			if (got.read_data !== want.read_data) begin
				$display("%0t: read_data mismatch: expected %h, actual %h",
					$time, want.read_data, got.read_data);
				n_errors++;
			end
		end
	endtask

	// result side: check each transfer, then pick the next stall
	int  hold_left = 0;
	bit  hold_seen = 1'b0;
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			check_rsp(rsp);
		if (hold_req && !hold_seen) begin
			hold_seen = 1'b1;
			hold_left = HOLD_LEN;
		end else if (!hold_req) begin
			hold_seen = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= ($urandom_range(0, 99) < rcv_idle);
		end
	end

	int quiet_cycles = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= IDLE_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
				$display("status: fail");
				$finish;
			end
		end
	end

	task automatic test_basic_ops();
		send_req(mk_req(nfsp_pkg::OP_ALLOC, 127, '0));
		send_req(mk_req(nfsp_pkg::OP_ALLOC, 0, '1));
		send_req(mk_req(nfsp_pkg::OP_WRITE, 0, '1));
		send_req(mk_req(nfsp_pkg::OP_WRITE, 1, '0));
		send_req(mk_req(nfsp_pkg::OP_READ, 0, '0));
		send_req(mk_req(nfsp_pkg::OP_READ, 1, '1));
		send_req(mk_req(nfsp_pkg::OP_WRITE, POOL - 1, 64'hA5C3_0F96_5A3C_F069));
		send_req(mk_req(nfsp_pkg::OP_READ, POOL - 1, '0));
		send_req(mk_req(nfsp_pkg::OP_FREE, 0, '0));
		send_req(mk_req(nfsp_pkg::OP_FREE, 0, '0));
		send_req(mk_req(nfsp_pkg::OP_ALLOC, 0, '0));
		send_req(mk_req(nfsp_pkg::OP_ALLOC, 64, '0));
	endtask

	task automatic test_out_of_range();
		send_req(mk_req(nfsp_pkg::OP_FREE, POOL, '0));
		send_req(mk_req(nfsp_pkg::OP_READ, 127, '0));
		send_req(mk_req(nfsp_pkg::OP_WRITE, POOL, '1));
		send_req(mk_req(nfsp_pkg::OP_READ, 100, '0));
		send_req(mk_req(nfsp_pkg::OP_FREE, 127, '1));
		send_req(mk_req(nfsp_pkg::OP_WRITE, 127, 64'h0123_4567_89AB_CDEF));
		send_req(mk_req(nfsp_pkg::OP_READ, POOL - 1, '0));
	endtask

	task automatic test_pool_full();
		repeat (POOL + 2)
			send_req(mk_req(nfsp_pkg::OP_ALLOC, int'($urandom_range(0, 127)), '0));
		send_req(mk_req(nfsp_pkg::OP_FREE, 37, '0));
		send_req(mk_req(nfsp_pkg::OP_ALLOC, 0, '0));
		send_req(mk_req(nfsp_pkg::OP_FREE, 5, '0));
		send_req(mk_req(nfsp_pkg::OP_FREE, 60, '0));
		send_req(mk_req(nfsp_pkg::OP_ALLOC, 0, '0));
		send_req(mk_req(nfsp_pkg::OP_ALLOC, 0, '0));
		send_req(mk_req(nfsp_pkg::OP_ALLOC, 0, '0));
		for (int s = 0; s < POOL; s++)
			send_req(mk_req(nfsp_pkg::OP_FREE, s, '0));
	endtask

	task automatic test_input_backpressure();
		send_idle = 0;
		rcv_idle  = 0;
		hold_req <= 1'b1;
		repeat (12)
			send_req(random_req());
		hold_req <= 1'b0;
	endtask

	task automatic test_drain_pause();
		repeat (6)
			send_req(random_req());
		req_valid <= 1'b0;
		@(posedge clk);
		wait (expected_rsp.size() == 0);
		repeat (6)
			send_req(random_req());
	endtask

	task automatic test_random(input int n_items, input int s_idle, input int r_idle);
		int sent;
		logic [nfsp_pkg::SLOT_BITS-1:0] g;
		send_idle = s_idle;
		rcv_idle  = r_idle;
		sent      = 0;
		while (sent < n_items) begin
			if ($urandom_range(0, 99) < 25) begin
				send_req(mk_req(nfsp_pkg::OP_ALLOC, int'($urandom_range(0, 127)),
					{$urandom, $urandom}));
				sent++;
				if (last_status == nfsp_pkg::ST_OK) begin
					g = last_grant;
					send_req(mk_req(nfsp_pkg::OP_WRITE, int'(g), {$urandom, $urandom}));
					send_req(mk_req(nfsp_pkg::OP_READ, int'(g), {$urandom, $urandom}));
					sent += 2;
				end
			end else begin
				send_req(random_req());
				sent++;
			end
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_basic_ops();
		test_out_of_range();
		test_pool_full();
		test_input_backpressure();
		test_drain_pause();
		test_random(250, 28, 55);
		test_random(250, 55, 28);
		test_random(250, 0, 0);
		req_valid <= 1'b0;
		wait (expected_rsp.size() == 0);
		repeat (10) @(posedge clk);
		$display("covered %0d requests: %0d allocates (%0d refused as full), %0d frees,",
			n_req, n_op[nfsp_pkg::OP_ALLOC], n_full, n_op[nfsp_pkg::OP_FREE]);
		$display("%0d reads, %0d writes, %0d out-of-range, %0d results checked, %0d mismatches",
			n_op[nfsp_pkg::OP_READ], n_op[nfsp_pkg::OP_WRITE], n_range, n_checked, n_errors);
		if (n_errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
